### rtl/grid_max_path_dp_defines.svh
// Assertion helpers for the grid max path block.
`ifndef GRID_MAX_PATH_DP_DEFINES_SVH
`define GRID_MAX_PATH_DP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define GMP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmp check failed");

// Next-cycle implication checked outside reset.
`define GMP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmp check failed");

// Next-cycle implication that also holds across reset.
`define GMP_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gmp reset check failed");

`endif

### rtl/gmp_pkg.sv
`timescale 1ns / 1ps
package gmp_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int VALUE_BITS = 8;

  localparam int ROW_BITS     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_BITS     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CNT_BITS = ROW_BITS + 1;
  localparam int COL_CNT_BITS = COL_BITS + 1;
  localparam int TOTAL_BITS   = $clog2(MAX_COLS * ((1 << VALUE_BITS) - 1) + 1);

  // Configuration port
  localparam int REG_BITS     = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COLS = 1'd1;

  // Control for one cell as it moves from the sequencer to the datapath
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [ROW_BITS-1:0] row_dn;
    logic                first_col;
    logic                has_up;
    logic                has_down;
    logic                last;
  } cell_ctl_t;

endpackage

### rtl/gmp_ram.sv
`timescale 1ns / 1ps
module gmp_ram import gmp_pkg::*; (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ROW_BITS-1:0]   waddr,
  input  logic [TOTAL_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [ROW_BITS-1:0]   raddr_a,
  input  logic [ROW_BITS-1:0]   raddr_b,
  output logic [TOTAL_BITS-1:0] rdata_a,
  output logic [TOTAL_BITS-1:0] rdata_b
);

  logic [TOTAL_BITS-1:0] mem [MAX_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/gmp_ctrl.sv
`timescale 1ns / 1ps
module gmp_ctrl import gmp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data,
  input  logic                    accept,
  output cell_ctl_t               ctl
);

  logic [REG_BITS-1:0]     num_rows;
  logic [REG_BITS-1:0]     num_cols;
  logic [ROW_BITS-1:0]     row_index;
  logic [COL_BITS-1:0]     col_index;
  logic [ROW_CNT_BITS-1:0] rows_eff;
  logic [COL_CNT_BITS-1:0] cols_eff;
  logic [ROW_CNT_BITS-1:0] row_plus;
  logic [COL_CNT_BITS-1:0] col_plus;
  logic                    has_down;
  logic                    more_cols;

  // Clamp the dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (num_rows == '0) begin
      rows_eff = ROW_CNT_BITS'(1);
    end else if (int'(num_rows) > MAX_ROWS) begin
      rows_eff = ROW_CNT_BITS'(MAX_ROWS);
    end else begin
      rows_eff = ROW_CNT_BITS'(num_rows);
    end
    if (num_cols == '0) begin
      cols_eff = COL_CNT_BITS'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols_eff = COL_CNT_BITS'(MAX_COLS);
    end else begin
      cols_eff = COL_CNT_BITS'(num_cols);
    end
  end

  assign row_plus  = {1'b0, row_index} + ROW_CNT_BITS'(1);
  assign col_plus  = {1'b0, col_index} + COL_CNT_BITS'(1);
  assign has_down  = row_plus < rows_eff;
  assign more_cols = col_plus < cols_eff;

  always_comb begin
    ctl.row       = row_index;
    ctl.row_dn    = row_plus[ROW_BITS-1:0];
    ctl.first_col = (col_index == '0);
    ctl.has_up    = (row_index != '0);
    ctl.has_down  = has_down;
    ctl.last      = !has_down && !more_cols;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= REG_BITS'(1);
      num_cols  <= REG_BITS'(1);
      row_index <= '0;
      col_index <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_data;
        CFG_NUM_COLS: num_cols <= cfg_data;
        default: ;
      endcase
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      if (has_down) begin
        row_index <= row_plus[ROW_BITS-1:0];
      end else begin
        row_index <= '0;
        col_index <= more_cols ? col_plus[COL_BITS-1:0] : '0;
      end
    end
  end

endmodule

### rtl/gmp_cell.sv
`timescale 1ns / 1ps
module gmp_cell import gmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  advance,
  input  logic [VALUE_BITS-1:0] gold,
  input  cell_ctl_t             ctl_in,
  input  logic [TOTAL_BITS-1:0] rdata_a,
  input  logic [TOTAL_BITS-1:0] rdata_b,
  output logic                  wr_en,
  output logic [ROW_BITS-1:0]   waddr,
  output logic [TOTAL_BITS-1:0] wdata,
  output logic                  final_pending,
  output logic                  res_valid,
  output logic [TOTAL_BITS-1:0] res_value
);

  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_gold;
  cell_ctl_t             s1_ctl;
  logic                  fwd_a;
  logic                  fwd_b;
  logic [TOTAL_BITS-1:0] fwd_data;
  logic [TOTAL_BITS-1:0] upper_left;
  logic [TOTAL_BITS-1:0] running_best;
  logic [TOTAL_BITS-1:0] old_val;
  logic [TOTAL_BITS-1:0] down_val;
  logic [TOTAL_BITS-1:0] best;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] running_best_next;

  assign old_val  = fwd_a ? fwd_data : rdata_a;
  assign down_val = fwd_b ? fwd_data : rdata_b;

  always_comb begin
    best = old_val;
    if (s1_ctl.has_up && (upper_left > best)) begin
      best = upper_left;
    end
    if (s1_ctl.has_down && (down_val > best)) begin
      best = down_val;
    end
    total = s1_ctl.first_col ? TOTAL_BITS'(s1_gold) : TOTAL_BITS'(s1_gold) + best;
    running_best_next = (!s1_ctl.has_up || (total > running_best)) ? total : running_best;
  end

  assign wr_en         = s1_valid && advance;
  assign waddr         = s1_ctl.row;
  assign wdata         = total;
  assign final_pending = s1_valid && s1_ctl.last;
  assign res_valid     = wr_en && s1_ctl.last;
  assign res_value     = running_best_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  // Capture the new cell; forward a total written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gold  <= gold;
      s1_ctl   <= ctl_in;
      fwd_a    <= wr_en && (waddr == ctl_in.row);
      fwd_b    <= wr_en && (waddr == ctl_in.row_dn);
      fwd_data <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left   <= '0;
      running_best <= '0;
    end else if (wr_en) begin
      upper_left   <= old_val;
      running_best <= running_best_next;
    end
  end

endmodule

### rtl/grid_max_path_dp.sv
`timescale 1ns / 1ps
// Order: an accepted cell beat writes its total when stage 1 advances; the
//   grid result is valid in the cycle after the last cell's total is formed.
// Throughput: one cell per cycle, set by the one-write, two-read column buffer; ready
//   drops only while a finished grid waits behind an untaken result.
// Reset: synchronous rst clears position counters, output valid and sets a 1x1 grid;
//   the column buffer is not cleared.
module grid_max_path_dp import gmp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_BITS-1:0]   gold,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TOTAL_BITS-1:0]   best_total
);

  // Stage 0 is the accept cycle: the sequencer gives the cell's row and
  // neighbor flags and the buffer reads this row and the row below.
  // Stage 1 has the read data: pick the best neighbor, add the cell value,
  // write the total back and track the column maximum.

  cell_ctl_t             ctl;
  logic                  accept;
  logic                  advance;
  logic                  stall;
  logic                  wr_en;
  logic [ROW_BITS-1:0]   waddr;
  logic [TOTAL_BITS-1:0] wdata;
  logic [TOTAL_BITS-1:0] rdata_a;
  logic [TOTAL_BITS-1:0] rdata_b;
  logic                  final_pending;
  logic                  res_valid;
  logic [TOTAL_BITS-1:0] res_value;

  // Hold stage 1 only when a second grid result meets an untaken one;
  // drop ready for that cycle so the buffer read data is not overwritten.
  assign stall    = final_pending && out_valid && !out_ready;
  assign advance  = !stall;
  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;

  gmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .ctl       (ctl)
  );

  gmp_ram u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (accept),
    .raddr_a (ctl.row),
    .raddr_b (ctl.row_dn),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  gmp_cell u_cell (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .advance       (advance),
    .gold          (gold),
    .ctl_in        (ctl),
    .rdata_a       (rdata_a),
    .rdata_b       (rdata_b),
    .wr_en         (wr_en),
    .waddr         (waddr),
    .wdata         (wdata),
    .final_pending (final_pending),
    .res_valid     (res_valid),
    .res_value     (res_value)
  );

  // Output register: load a grid result, clear once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      best_total <= res_value;
    end
  end

endmodule

### rtl/gmp_checker.sv
`timescale 1ns / 1ps
`include "grid_max_path_dp_defines.svh"
module gmp_checker import gmp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [TOTAL_BITS-1:0] best_total
);

  `GMP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_total))
  `GMP_ASSERT_IMP(a_ready_only_blocked, !in_ready, out_valid)
  `GMP_ASSERT_IMP(a_result_from_beat, $rose(out_valid), $past(in_valid && in_ready, 2))
  `GMP_ASSERT_RST(a_reset_clears, rst, !out_valid)

endmodule

bind grid_max_path_dp gmp_checker u_gmp_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

import gmp_pkg::*;

// Scoreboard: a cell-by-cell copy of the gold-mine recurrence plus the queue of grid
// totals it expects to see on the result channel.
class grid_score;

  logic [TOTAL_BITS-1:0] col_sum [MAX_ROWS];
  logic [TOTAL_BITS-1:0] up_left;
  logic [TOTAL_BITS-1:0] best_so_far;
  logic [TOTAL_BITS-1:0] want_q [$];
  int unsigned           row_pos;
  int unsigned           col_pos;
  int unsigned           rows_reg;
  int unsigned           cols_reg;
  int unsigned           cells_seen;
  int unsigned           totals_checked;
  int unsigned           errors;

  function new();
    foreach (col_sum[i]) col_sum[i] = '0;
    rows_reg       = 1;
    cols_reg       = 1;
    cells_seen     = 0;
    totals_checked = 0;
    errors         = 0;
    restart_grid();
  endfunction

  function void restart_grid();
    row_pos     = 0;
    col_pos     = 0;
    up_left     = '0;
    best_so_far = '0;
  endfunction

  function int unsigned fit_dim(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    if (idx == CFG_NUM_ROWS) rows_reg = val;
    else if (idx == CFG_NUM_COLS) cols_reg = val;
    else return;
    restart_grid();
  endfunction

  // Note one accepted cell beat; queue the grid total when it closes the grid.
  function void note_cell(logic [VALUE_BITS-1:0] g);
    int unsigned           rows;
    int unsigned           cols;
    int unsigned           r;
    int unsigned           c;
    logic [TOTAL_BITS-1:0] old;
    logic [TOTAL_BITS-1:0] best;
    logic [TOTAL_BITS-1:0] tot;
    rows = fit_dim(rows_reg, MAX_ROWS);
    cols = fit_dim(cols_reg, MAX_COLS);
    r = row_pos;
    c = col_pos;
    if (r >= rows) r = rows - 1;
    if (c >= cols) c = cols - 1;
    old = col_sum[r];
    if (c == 0) begin
      tot = TOTAL_BITS'(g);
    end else begin
      best = old;
      if (r > 0 && up_left > best) best = up_left;
      if (r + 1 < rows && col_sum[r+1] > best) best = col_sum[r+1];
      tot = TOTAL_BITS'(g) + best;
    end
    col_sum[r] = tot;
    up_left    = old;
    if (r == 0 || tot > best_so_far) best_so_far = tot;
    cells_seen++;
    if (r + 1 < rows) begin
      row_pos = r + 1;
      return;
    end
    row_pos = 0;
    up_left = '0;
    if (c + 1 < cols) begin
      col_pos = c + 1;
      return;
    end
    want_q.push_back(best_so_far);
    restart_grid();
  endfunction

  function void check_result(logic [TOTAL_BITS-1:0] got);
    logic [TOTAL_BITS-1:0] want;
    if (want_q.size() == 0) begin
      $error("best_total: no grid total expected, got %0d", got);
      errors++;
      return;
    end
    want = want_q.pop_front();
    totals_checked++;
    if (got !== want) begin
      $error("best_total mismatch: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return want_q.size();
  endfunction
endclass

module tb_top;
  import gmp_pkg::*;

  localparam int ITEMS        = 1600;
  localparam int LIMIT_CYCLES = 400000;
  // Cycles to let the pipeline empty once the last grid total has come back.
  localparam int SETTLE       = 10;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0]     cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [VALUE_BITS-1:0]   gold;
  logic                    out_valid;
  logic                    out_ready;
  logic [TOTAL_BITS-1:0]   best_total;

  grid_score   gold_paths = new();
  bit          calm = 1'b0;   // set near the end: no gaps, no stalls
  int unsigned cycle_count = 0;
  int unsigned settings_done = 0;
  bit          held_for_totals = 1'b0;

  always #5 clk = ~clk;

  grid_max_path_dp u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .gold      (gold),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .best_total(best_total)
  );

  // Sample both channels at the edge. Inputs are noted before results are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) gold_paths.note_cell(gold);
      if (out_valid && out_ready) gold_paths.check_result(best_total);
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: mix bursts of ready with bursts of stall; once the
  // run turns calm, hold ready high for good.
  initial begin
    out_ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Write one register; the predictor follows at the write edge. Called with no cell
  // beat in flight. Drop the enable after each write so writes never share a step.
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    gold_paths.set_reg(idx, val);
    cfg_we    <= 1'b0;
    settings_done++;
    @(posedge clk);
  endtask

  // Present one cell beat and hold it until accepted. Drop valid only when a gap is
  // taken, so valid never falls and rises within one step.
  task automatic send_cell(logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    gold     <= v;
    do @(posedge clk); while (!in_ready);
    if (gold_paths.cells_seen >= ITEMS * 7 / 8) calm = 1'b1;
  endtask

  // Hold the sender until every queued grid total has come back. Step one edge first
  // so the last accepted cell has been noted.
  task automatic wait_totals();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gold_paths.pending() != 0) @(posedge clk);
  endtask

  // Wait out the results, then let any trailing cells with no result leave the pipe.
  task automatic settle();
    wait_totals();
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_gold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom_range(0, (1 << VALUE_BITS) - 1));
    endcase
  endfunction

  task automatic run_cells(int unsigned n, bit all_max);
    for (int unsigned i = 0; i < n; i++) send_cell(all_max ? '1 : pick_gold());
  endtask

  function automatic int unsigned eff_dim(int unsigned v, int unsigned top);
    return (v == 0) ? 1 : (v > top ? top : v);
  endfunction

  // One register setting: a few full grids with random content, pauses for the
  // totals now and then, sometimes an abandoned partial grid, then go idle.
  task automatic run_setting();
    int unsigned kind;
    int unsigned r;
    int unsigned c;
    int unsigned n;
    int unsigned grids;
    kind = $urandom_range(0, 11);
    case (kind)
      0: begin
        r = $urandom_range(0, 1) ? MAX_ROWS : $urandom_range(MAX_ROWS + 1, 127);
        c = $urandom_range(1, 3);
      end
      1: begin
        r = $urandom_range(1, 2);
        c = $urandom_range(0, 1) ? MAX_COLS : $urandom_range(MAX_COLS + 1, 127);
      end
      2: begin
        r = 0;
        c = $urandom_range(0, 4);
      end
      3: begin
        r = $urandom_range(1, 4);
        c = 0;
      end
      default: begin
        r = $urandom_range(1, 8);
        c = $urandom_range(1, 8);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_NUM_ROWS, REG_BITS'(r));
      write_reg(CFG_NUM_COLS, REG_BITS'(c));
    end else begin
      write_reg(CFG_NUM_COLS, REG_BITS'(c));
      write_reg(CFG_NUM_ROWS, REG_BITS'(r));
    end
    n = eff_dim(r, MAX_ROWS) * eff_dim(c, MAX_COLS);
    grids = (n >= 120) ? 1 : $urandom_range(1, (120 / n > 6) ? 6 : 120 / n);
    for (int unsigned g = 0; g < grids; g++) begin
      // A wide grid of all-maximum cells reaches the largest possible total.
      run_cells(n, (kind == 1 && g == 0) || $urandom_range(0, 15) == 0);
      if (!held_for_totals || $urandom_range(0, 7) == 0) begin
        wait_totals();
        held_for_totals = 1'b1;
      end
    end
    if (n > 1 && $urandom_range(0, 3) == 0) run_cells($urandom_range(1, n - 1), 1'b0);
    settle();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_NUM_ROWS;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    gold      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset leaves a 1x1 grid: every cell is its own total.
    send_cell('0);
    send_cell('1);
    settle();

    // 3x3 grid: edge rows see only two neighbors, the middle row all three.
    write_reg(CFG_NUM_ROWS, REG_BITS'(3));
    write_reg(CFG_NUM_COLS, REG_BITS'(3));
    send_cell(8'd1);   send_cell(8'd2);   send_cell(8'd3);
    send_cell(8'd0);   send_cell(8'd200); send_cell(8'd0);
    send_cell(8'd255); send_cell(8'd0);   send_cell(8'd7);
    settle();

    // Single row over several columns: a straight path.
    write_reg(CFG_NUM_ROWS, REG_BITS'(1));
    write_reg(CFG_NUM_COLS, REG_BITS'(3));
    send_cell(8'd10);  send_cell(8'd255); send_cell(8'd0);
    settle();

    // Abandon a 2x2 grid midway; the register write must restart it.
    write_reg(CFG_NUM_ROWS, REG_BITS'(2));
    write_reg(CFG_NUM_COLS, REG_BITS'(2));
    send_cell(8'd90);  send_cell(8'd91);  send_cell(8'd92);
    settle();
    write_reg(CFG_NUM_ROWS, REG_BITS'(2));
    send_cell(8'd5);   send_cell(8'd250); send_cell(8'd1);   send_cell(8'd0);
    settle();

    // Zero in both registers acts as one.
    write_reg(CFG_NUM_ROWS, REG_BITS'(0));
    write_reg(CFG_NUM_COLS, REG_BITS'(0));
    send_cell('1);
    send_cell(8'd0);
    settle();

    while (gold_paths.cells_seen < ITEMS) run_setting();

    settle();
    if (gold_paths.pending() != 0) begin
      $error("best_total: %0d grid totals never arrived", gold_paths.pending());
      gold_paths.errors++;
    end

    $display("Streamed %0d cells under %0d register writes; checked %0d grid totals.",
             gold_paths.cells_seen, settings_done, gold_paths.totals_checked);
    if (gold_paths.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/gmp_pkg.sv
rtl/gmp_ram.sv
rtl/gmp_ctrl.sv
rtl/gmp_cell.sv
rtl/grid_max_path_dp.sv
rtl/gmp_checker.sv
sim/tb_top.sv
